// File: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit.
// Holds operation and status codes and the queue entry format.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Operation codes.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_INC = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Magnitude width of raw intermediates (two 32-bit magnitudes, one add).
  localparam int MAG_W = 65;

  // One classified request passed from the front part to the back part.
  typedef struct packed {
    logic             neg;     // result sign
    logic [MAG_W-1:0] nmag;    // raw numerator magnitude
    logic [MAG_W-1:0] dmag;    // raw denominator magnitude
    logic             zden;    // zero denominator or undefined op
    logic             znum;    // zero numerator
  } rau_job_t;

endpackage

// File: design/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: request and result channels.
// Valid/ready handshake carrying the operand or result payload.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] left_num;
  logic signed [31:0] left_den;
  logic signed [31:0] right_num;
  logic signed [31:0] right_den;

  modport source (output valid, op, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, op, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface

// File: design/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front: request intake and classification.
// Multiplies the cross products and forms raw magnitudes.
// ----------------------------------------------------------------------------
module rau_front
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  rau_in_if.sink         in_if,
  output logic           job_valid,
  input  logic           job_ready,
  output rau_job_t       job
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} st_t;

  st_t             st_r;
  logic [2:0]      op_r;
  logic [WIDTH-1:0] a_r [4];   // magnitudes ln, ld, rn, rd
  logic [3:0]      s_r;        // signs ln, ld, rn, rd
  logic [2*WIDTH-1:0] p0_r, p1_r, p2_r;
  logic            p0n_r, p1n_r, p2n_r;
  rau_job_t        job_r;

  // Magnitude of an operand read within WIDTH bits.
  function automatic logic [WIDTH-1:0] mag_of(input logic [31:0] v);
    logic [WIDTH-1:0] t;
    t = v[WIDTH-1:0];
    return t[WIDTH-1] ? (~t + 1'b1) : t;
  endfunction

  assign in_if.ready = (st_r == S_IDLE);
  assign job_valid   = (st_r == S_OUT);
  assign job         = job_r;

  // Product operand selection per operation.
  logic [WIDTH-1:0] m0a, m0b, m1a, m1b, m2a, m2b;
  logic             m0n, m1n, m2n;
  always_comb begin
    // p0: first numerator term, p1: second numerator term, p2: denominator.
    m0a = a_r[0]; m0b = a_r[3]; m0n = s_r[0] ^ s_r[3];
    m1a = a_r[2]; m1b = a_r[1]; m1n = s_r[2] ^ s_r[1] ^ (op_r == OP_SUB);
    m2a = a_r[1]; m2b = a_r[3]; m2n = s_r[1] ^ s_r[3];
    case (op_r)
      OP_MUL: begin
        m0b = a_r[2]; m0n = s_r[0] ^ s_r[2];
        m1a = '0;
      end
      OP_DIV: begin
        m1a = '0;
        m2a = a_r[2]; m2b = a_r[1]; m2n = s_r[2] ^ s_r[1];
      end
      OP_INC: begin
        m0b = WIDTH'(1); m0n = s_r[0];
        m1a = a_r[1]; m1b = WIDTH'(1); m1n = s_r[1];
        m2b = WIDTH'(1); m2n = s_r[1];
      end
      default: ;
    endcase
  end

  // Signed-magnitude sum of the two numerator terms.
  logic [MAG_W-1:0] x, y, sum;
  logic             sneg;
  always_comb begin
    x = MAG_W'(p0_r);
    y = MAG_W'(p1_r);
    if (p0n_r == p1n_r) begin
      sum = x + y; sneg = p0n_r;
    end else if (x >= y) begin
      sum = x - y; sneg = p0n_r;
    end else begin
      sum = y - x; sneg = p1n_r;
    end
  end

  // Sequencer: capture, multiply, sum, hand off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_if.valid) begin
            op_r   <= in_if.op;
            a_r[0] <= mag_of(in_if.left_num);
            a_r[1] <= mag_of(in_if.left_den);
            a_r[2] <= mag_of(in_if.right_num);
            a_r[3] <= mag_of(in_if.right_den);
            s_r    <= {in_if.right_den[WIDTH-1], in_if.right_num[WIDTH-1],
                       in_if.left_den[WIDTH-1], in_if.left_num[WIDTH-1]};
            st_r   <= S_MUL;
          end
        end
        S_MUL: begin
          p0_r <= m0a * m0b; p0n_r <= m0n;
          p1_r <= m1a * m1b; p1n_r <= m1n;
          p2_r <= m2a * m2b; p2n_r <= m2n;
          st_r <= S_SUM;
        end
        S_SUM: begin
          job_r.nmag <= sum;
          job_r.dmag <= MAG_W'(p2_r);
          job_r.neg  <= sneg ^ p2n_r;
          job_r.zden <= (p2_r == '0) || (op_r > OP_INC);
          job_r.znum <= (sum == '0);
          st_r       <= S_OUT;
        end
        S_OUT: begin
          if (job_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue: two-entry queue between front and back parts.
// Lets intake continue while the reduction unit is busy.
// ----------------------------------------------------------------------------
module rau_queue
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  rau_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output rau_job_t rd_data
);

  rau_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Storage entries.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// File: design/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back: reduction unit.
// Binary GCD then restoring division of both magnitudes, one step a cycle.
// ----------------------------------------------------------------------------
module rau_back
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  rau_job_t  job,
  rau_out_if.source out_if
);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_GCD, S_DIV, S_CHK, S_OUT} st_t;

  localparam int CW = $clog2(MAG_W + 1);
  localparam logic [MAG_W-1:0] LIM = MAG_W'((65'd1 << (WIDTH - 1)) - 65'd1);

  st_t              st_r;
  logic             neg_r;
  logic [MAG_W-1:0] n_r, d_r, u_r, v_r;
  logic [CW-1:0]    k_r, cnt_r;
  logic [MAG_W-1:0] g_r;
  logic [MAG_W-1:0] qn_r, qd_r, rn_r, rd_r;
  logic signed [31:0] res_num_r;
  logic [30:0]      res_den_r;
  logic [1:0]       status_r;

  assign job_ready      = (st_r == S_IDLE);
  assign out_if.valid   = (st_r == S_OUT);
  assign out_if.res_num = res_num_r;
  assign out_if.res_den = res_den_r;
  assign out_if.status  = status_r;

  // One restoring-division step for each quotient.
  logic [MAG_W:0]   trn, trd;
  logic [MAG_W-1:0] bn, bd;
  always_comb begin
    bn  = n_r >> cnt_r;
    bd  = d_r >> cnt_r;
    trn = {rn_r, bn[0]} - {1'b0, g_r};
    trd = {rd_r, bd[0]} - {1'b0, g_r};
  end

  logic [MAG_W-1:0] negv;
  assign negv = ~qn_r + 1'b1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            n_r <= job.nmag; d_r <= job.dmag; neg_r <= job.neg;
            u_r <= job.nmag; v_r <= job.dmag; k_r <= '0;
            if (job.zden) begin
              res_num_r <= '0; res_den_r <= '0; status_r <= ST_ZDEN;
              st_r <= S_OUT;
            end else if (job.znum) begin
              res_num_r <= '0; res_den_r <= 31'd1; status_r <= ST_OK;
              st_r <= S_OUT;
            end else begin
              st_r <= S_SHIFT;
            end
          end
        end
        // Strip common factors of two.
        S_SHIFT: begin
          if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1; v_r <= v_r >> 1; k_r <= k_r + 1'b1;
          end else begin
            st_r <= S_GCD;
          end
        end
        // Binary GCD on the odd part.
        S_GCD: begin
          if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r == v_r) begin
            g_r   <= u_r << k_r;
            cnt_r <= CW'(MAG_W - 1);
            rn_r  <= '0; rd_r <= '0; qn_r <= '0; qd_r <= '0;
            st_r  <= S_DIV;
          end else if (u_r > v_r) begin
            u_r <= (u_r - v_r) >> 1;
          end else begin
            v_r <= (v_r - u_r) >> 1;
          end
        end
        // Divide both magnitudes by the GCD, one bit a cycle.
        S_DIV: begin
          if (!trn[MAG_W]) begin
            rn_r <= trn[MAG_W-1:0]; qn_r <= {qn_r[MAG_W-2:0], 1'b1};
          end else begin
            rn_r <= {rn_r[MAG_W-2:0], bn[0]}; qn_r <= {qn_r[MAG_W-2:0], 1'b0};
          end
          if (!trd[MAG_W]) begin
            rd_r <= trd[MAG_W-1:0]; qd_r <= {qd_r[MAG_W-2:0], 1'b1};
          end else begin
            rd_r <= {rd_r[MAG_W-2:0], bd[0]}; qd_r <= {qd_r[MAG_W-2:0], 1'b0};
          end
          if (cnt_r == '0) st_r <= S_CHK;
          else cnt_r <= cnt_r - 1'b1;
        end
        // Range check and sign placement.
        S_CHK: begin
          if ((qd_r > LIM) || (neg_r ? (qn_r > LIM + 1'b1) : (qn_r > LIM))) begin
            res_num_r <= '0; res_den_r <= '0; status_r <= ST_OVF;
          end else begin
            res_num_r <= neg_r ? negv[31:0] : qn_r[31:0];
            res_den_r <= qd_r[30:0];
            status_r  <= ST_OK;
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_if.ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: signed fraction ALU with GCD reduction.
// Front part forms cross products, back part reduces by the GCD.
// ----------------------------------------------------------------------------
// The front part multiplies, then sums; the reduction unit runs the binary GCD, then
// 65 division steps. Zero cases skip the reduction and go straight to the output.
// The reduction unit takes a new request only after its last result has been accepted.
// Reset: synchronous active-low rst_n empties the queue and idles both parts.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rau_in_if.sink     in_if,
  rau_out_if.source  out_if
);

  logic     f_valid, f_ready, b_valid, b_ready;
  rau_job_t f_job, b_job;

  // Request intake.
  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk, .rst_n, .in_if,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // Decoupling queue.
  rau_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  // Reduction.
  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job), .out_if
  );

endmodule
